### sv/sctt_pkg.sv
// Shared types, sizes and opcodes for the sorted cue time table.
// No dependencies; used by every other file of the block.
`default_nettype none

package sctt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int TIME_W      = 32;
    localparam int HANDLE_W    = 16;
    localparam int OP_W        = 3;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_OFFSET = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    typedef enum logic {
        ALU_CMP = 1'b0,   // b - a, sign gives a <= b
        ALU_ADD = 1'b1    // a + signed b, clamped to the unsigned range
    } t_alu_mode;

    typedef struct packed {
        logic [TIME_W-1:0]   tm;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic                we;
        logic [IDX_W-1:0]    waddr;
        t_entry              wdata;
        logic [IDX_W-1:0]    raddr;
    } t_mem_req;

    typedef struct packed {
        logic                ok;
        logic                current_valid;
        logic [IDX_W-1:0]    current_index;
        logic                exact_found;
        logic                previous_valid;
        logic [IDX_W-1:0]    previous_index;
        logic                next_valid;
        logic [IDX_W-1:0]    next_index;
        logic [TIME_W-1:0]   entry_time;
        logic [HANDLE_W-1:0] entry_handle;
        logic [CNT_W-1:0]    entry_count;
    } t_result;

endpackage

`default_nettype wire

### sv/sctt_mem.sv
// Entry store: one write port, one read port with registered read data.
// Depends on sctt_pkg.
`default_nettype none

module sctt_mem (
    input  wire logic              i_clk,
    input  wire sctt_pkg::t_mem_req i_req,
    output sctt_pkg::t_entry       o_rdata
);

    sctt_pkg::t_entry r_mem [sctt_pkg::TABLE_DEPTH];
    sctt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/sctt_alu.sv
// Shared 34-bit add/compare unit with saturation to the unsigned time range.
// Depends on sctt_pkg.
`default_nettype none

module sctt_alu (
    input  wire sctt_pkg::t_alu_mode           i_mode,
    input  wire logic [sctt_pkg::TIME_W-1:0]   i_a,
    input  wire logic [sctt_pkg::TIME_W-1:0]   i_b,
    output logic                               o_le,
    output logic [sctt_pkg::TIME_W-1:0]        o_sum
);

    localparam int W = sctt_pkg::TIME_W + 2;

    logic [W-1:0] opa;
    logic [W-1:0] opb;
    logic [W-1:0] sum;

    always_comb begin
        case (i_mode)
            sctt_pkg::ALU_ADD: begin
                opa = {2'b00, i_a};
                opb = {{2{i_b[sctt_pkg::TIME_W-1]}}, i_b};
            end
            default: begin
                opa = {2'b00, i_b};
                opb = ~{2'b00, i_a} + W'(1);
            end
        endcase
        sum  = opa + opb;
        // compare: b - a not negative means a <= b
        o_le = ~sum[W-1];
        if (sum[W-1]) begin
            o_sum = '0;
        end else if (sum[W-2]) begin
            o_sum = '1;
        end else begin
            o_sum = sum[sctt_pkg::TIME_W-1:0];
        end
    end

endmodule

`default_nettype wire

### sv/sctt_seq.sv
// Operation sequencer: drives the entry store and the shared add/compare
// unit for insert shifting, offset sweep, binary search and reads.
// Depends on sctt_pkg.
`default_nettype none

module sctt_seq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic [sctt_pkg::OP_W-1:0]       i_opcode,
    input  wire logic [sctt_pkg::TIME_W-1:0]     i_time_value,
    input  wire logic [sctt_pkg::HANDLE_W-1:0]   i_text_handle,
    input  wire logic [sctt_pkg::IDX_W-1:0]      i_entry_index,
    input  wire logic [sctt_pkg::TIME_W-1:0]     i_offset,
    input  wire logic                            i_res_ready,
    input  wire sctt_pkg::t_entry                i_rdata,
    input  wire logic                            i_alu_le,
    input  wire logic [sctt_pkg::TIME_W-1:0]     i_alu_sum,
    output sctt_pkg::t_alu_mode                  o_alu_mode,
    output logic [sctt_pkg::TIME_W-1:0]          o_alu_b,
    output sctt_pkg::t_mem_req                   o_mem_req,
    output logic                                 o_busy,
    output logic                                 o_res_valid,
    output sctt_pkg::t_result                    o_res
);

    localparam int CW = sctt_pkg::CNT_W;
    localparam int IW = sctt_pkg::IDX_W;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_INS_CMP  = 8'b0000_0010,
        S_INS_WR   = 8'b0000_0100,
        S_OFS      = 8'b0000_1000,
        S_SRCH_RD  = 8'b0001_0000,
        S_SRCH_CMP = 8'b0010_0000,
        S_RD_WAIT  = 8'b0100_0000,
        S_OUT      = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [sctt_pkg::TIME_W-1:0]   r_key_time, n_key_time;
    logic [sctt_pkg::HANDLE_W-1:0] r_key_handle, n_key_handle;
    sctt_pkg::t_result r_res, n_res;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic [CW-1:0] pos_m1;
    logic [CW-1:0] pos_m2;
    logic [CW-1:0] pos_p1;
    logic [CW-1:0] lo_m1;
    logic [CW-1:0] lo_m2;
    logic [CW-1:0] in_idx;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];
    assign pos_m1  = r_pos - CW'(1);
    assign pos_m2  = r_pos - CW'(2);
    assign pos_p1  = r_pos + CW'(1);
    assign lo_m1   = r_lo - CW'(1);
    assign lo_m2   = r_lo - CW'(2);
    assign in_idx  = {1'b0, i_entry_index};

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_key_time   = r_key_time;
        n_key_handle = r_key_handle;
        n_res        = r_res;
        o_mem_req.we          = 1'b0;
        o_mem_req.waddr       = r_pos[IW-1:0];
        o_mem_req.wdata.tm    = r_key_time;
        o_mem_req.wdata.handle = r_key_handle;
        o_mem_req.raddr       = pos_m1[IW-1:0];
        o_alu_mode  = sctt_pkg::ALU_CMP;
        o_alu_b     = r_key_time;
        o_res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key_time   = i_time_value;
                    n_key_handle = i_text_handle;
                    n_res        = '0;
                    n_res.ok     = 1'b1;
                    n_state      = S_OUT;
                    case (i_opcode)
                        sctt_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        sctt_pkg::OP_INSERT: begin
                            n_pos = r_count;
                            if (r_count >= CW'(sctt_pkg::TABLE_DEPTH)) begin
                                n_res.ok = 1'b0;
                            end else if (r_count == '0) begin
                                n_state = S_INS_WR;
                            end else begin
                                o_mem_req.raddr = IW'(r_count - CW'(1));
                                n_state = S_INS_CMP;
                            end
                        end
                        sctt_pkg::OP_OFFSET: begin
                            n_pos = '0;
                            o_mem_req.raddr = '0;
                            if (i_offset != '0 && r_count != '0) begin
                                n_state = S_OFS;
                            end
                        end
                        sctt_pkg::OP_FIND: begin
                            n_lo    = '0;
                            n_hi    = r_count;
                            n_state = S_SRCH_RD;
                        end
                        sctt_pkg::OP_READ: begin
                            o_mem_req.raddr = i_entry_index;
                            if (in_idx < r_count) begin
                                n_state = S_RD_WAIT;
                            end else begin
                                n_res.ok = 1'b0;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_INS_CMP: begin
                // read data is entry pos-1; shift it up while it is later
                if (!i_alu_le) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.wdata = i_rdata;
                    n_pos           = pos_m1;
                    o_mem_req.raddr = pos_m2[IW-1:0];
                    if (pos_m1 == '0) begin
                        n_state = S_INS_WR;
                    end
                end else begin
                    o_mem_req.we = 1'b1;
                    n_count      = r_count + CW'(1);
                    n_state      = S_OUT;
                end
            end
            S_INS_WR: begin
                o_mem_req.we = 1'b1;
                n_count      = r_count + CW'(1);
                n_state      = S_OUT;
            end
            S_OFS: begin
                o_alu_mode = sctt_pkg::ALU_ADD;
                o_alu_b    = i_offset;
                o_mem_req.we           = 1'b1;
                o_mem_req.wdata.tm     = i_alu_sum;
                o_mem_req.wdata.handle = i_rdata.handle;
                o_mem_req.raddr        = pos_p1[IW-1:0];
                n_pos = pos_p1;
                if (pos_p1 == r_count) begin
                    n_state = S_OUT;
                end
            end
            S_SRCH_RD: begin
                o_mem_req.raddr = mid[IW-1:0];
                if (r_lo < r_hi) begin
                    n_state = S_SRCH_CMP;
                end else begin
                    n_state = S_OUT;
                    if (r_lo != '0) begin
                        n_res.current_valid = 1'b1;
                        n_res.current_index = lo_m1[IW-1:0];
                        n_res.exact_found   = 1'b1;
                        if (lo_m1 != '0) begin
                            n_res.previous_valid = 1'b1;
                            n_res.previous_index = lo_m2[IW-1:0];
                        end
                        if (r_lo < r_count) begin
                            n_res.next_valid = 1'b1;
                            n_res.next_index = r_lo[IW-1:0];
                        end
                    end else begin
                        n_res.current_valid = (r_count != '0);
                        if (r_count > CW'(1)) begin
                            n_res.next_valid = 1'b1;
                            n_res.next_index = IW'(1);
                        end
                    end
                end
            end
            S_SRCH_CMP: begin
                o_mem_req.raddr = mid[IW-1:0];
                if (i_alu_le) begin
                    n_lo = mid + CW'(1);
                end else begin
                    n_hi = mid;
                end
                n_state = S_SRCH_RD;
            end
            S_RD_WAIT: begin
                n_res.entry_time   = i_rdata.tm;
                n_res.entry_handle = i_rdata.handle;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos        <= n_pos;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_key_time   <= n_key_time;
        r_key_handle <= n_key_handle;
        r_res        <= n_res;
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_res             = r_res;
        o_res.entry_count = r_count;
    end

endmodule

`default_nettype wire

### sv/sorted_cue_time_table_top.sv
// Top level of the sorted cue time table: ports, offset register, result register.
// Depends on sctt_pkg, sctt_mem, sctt_alu and sctt_seq.
`default_nettype none

// Usage
//   Input channel (i_in_valid / o_in_stall): one operation per transfer:
//   clear, insert, apply offset, find window or read entry. One operation at
//   a time; the input stalls until its result is handed to the output register.
//   Output channel (o_out_valid / i_out_stall): exactly one result per
//   operation, in order. The result sits in a register, so a stalled receiver
//   only holds the block in its final step; o_out_valid stays high with a
//   steady payload until the transfer happens.
//   Config: i_cfg_we writes the signed offset used by apply offset; write it
//   only while no operation is in flight.
//   Steps per operation, input transfer to result valid: clear, bad read,
//   full insert, unknown opcode and zero offset go straight to the result;
//   read entry waits for the registered read data; find window runs a
//   binary search over the held entries; insert shifts every later entry
//   up by one; apply offset rewrites every held entry in turn.
//   One read and one write port on the entry store, one shift or add per
//   cycle; each search probe is a registered read, then a compare.
//   Reset: synchronous, active low; empties the table, zeroes the offset and
//   drops any pending result. Entry contents are not cleared.

module sorted_cue_time_table_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [sctt_pkg::OP_W-1:0]       i_opcode,
    input  wire logic [sctt_pkg::TIME_W-1:0]     i_time_value,
    input  wire logic [sctt_pkg::HANDLE_W-1:0]   i_text_handle,
    input  wire logic [sctt_pkg::IDX_W-1:0]      i_entry_index,
    input  wire logic                            i_cfg_we,
    input  wire logic [sctt_pkg::TIME_W-1:0]     i_cfg_wdata,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_ok,
    output logic                                 o_current_valid,
    output logic [sctt_pkg::IDX_W-1:0]           o_current_index,
    output logic                                 o_exact_found,
    output logic                                 o_previous_valid,
    output logic [sctt_pkg::IDX_W-1:0]           o_previous_index,
    output logic                                 o_next_valid,
    output logic [sctt_pkg::IDX_W-1:0]           o_next_index,
    output logic [sctt_pkg::TIME_W-1:0]          o_entry_time,
    output logic [sctt_pkg::HANDLE_W-1:0]        o_entry_handle,
    output logic [sctt_pkg::CNT_W-1:0]           o_entry_count
);

    logic [sctt_pkg::TIME_W-1:0] r_offset;
    logic                        r_out_valid;
    sctt_pkg::t_result           r_out;

    sctt_pkg::t_mem_req          mem_req;
    sctt_pkg::t_entry            mem_rdata;
    sctt_pkg::t_alu_mode         alu_mode;
    logic [sctt_pkg::TIME_W-1:0] alu_b;
    logic                        alu_le;
    logic [sctt_pkg::TIME_W-1:0] alu_sum;
    logic                        busy;
    logic                        res_ready;
    logic                        res_valid;
    sctt_pkg::t_result           res;

    // result slot is free when empty or being drained this cycle
    assign res_ready = !r_out_valid || !i_out_stall;

    sctt_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // one compare/add unit shared by insert, search and offset sweep
    sctt_alu u_alu (
        .i_mode (alu_mode),
        .i_a    (mem_rdata.tm),
        .i_b    (alu_b),
        .o_le   (alu_le),
        .o_sum  (alu_sum)
    );

    sctt_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_opcode      (i_opcode),
        .i_time_value  (i_time_value),
        .i_text_handle (i_text_handle),
        .i_entry_index (i_entry_index),
        .i_offset      (r_offset),
        .i_res_ready   (res_ready),
        .i_rdata       (mem_rdata),
        .i_alu_le      (alu_le),
        .i_alu_sum     (alu_sum),
        .o_alu_mode    (alu_mode),
        .o_alu_b       (alu_b),
        .o_mem_req     (mem_req),
        .o_busy        (busy),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_offset <= i_cfg_wdata;
            end
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_in_stall       = busy;
    assign o_out_valid      = r_out_valid;
    assign o_ok             = r_out.ok;
    assign o_current_valid  = r_out.current_valid;
    assign o_current_index  = r_out.current_index;
    assign o_exact_found    = r_out.exact_found;
    assign o_previous_valid = r_out.previous_valid;
    assign o_previous_index = r_out.previous_index;
    assign o_next_valid     = r_out.next_valid;
    assign o_next_index     = r_out.next_index;
    assign o_entry_time     = r_out.entry_time;
    assign o_entry_handle   = r_out.entry_handle;
    assign o_entry_count    = r_out.entry_count;

endmodule

`default_nettype wire

### sv/sctt_chk.sv
// Port-level checker for the sorted cue time table, bound to the top level.
// Depends on sctt_pkg and sorted_cue_time_table_top.
`default_nettype none

module sctt_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic                            o_ok,
    input wire logic                            o_current_valid,
    input wire logic [sctt_pkg::IDX_W-1:0]      o_current_index,
    input wire logic                            o_exact_found,
    input wire logic                            o_previous_valid,
    input wire logic [sctt_pkg::IDX_W-1:0]      o_previous_index,
    input wire logic [sctt_pkg::TIME_W-1:0]     o_entry_time,
    input wire logic [sctt_pkg::CNT_W-1:0]      o_entry_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an operation is in flight");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= sctt_pkg::CNT_W'(sctt_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");

    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_previous_valid |->
            o_current_valid && o_exact_found &&
            o_previous_index == o_current_index - sctt_pkg::IDX_W'(1))
        else $error("previous index not adjacent to current");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_entry_time == '0)
        else $error("rejected result carries entry data");

endmodule

bind sorted_cue_time_table_top sctt_chk u_sctt_chk (.*);

`default_nettype wire

### bench/tb.sv
// Self-checking bench for sorted_cue_time_table_top: directed corner cases, then
// random mixes of every opcode, unused codes included, checked against a mirror.
// Depends on sctt_pkg and the sorted_cue_time_table_top RTL.
`default_nettype none

module tb;

    // Watchdog: cycles with no transfer on either channel before giving up.
    // Sized to cover the slowest op plus a receiver stall burst and an input gap.
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 300;

    localparam int SHIFT_MAX = 2147483647;
    localparam int SHIFT_MIN = -SHIFT_MAX;

    // Codes above OP_READ do nothing in the block.
    localparam logic [sctt_pkg::OP_W-1:0] OP_NONE_FIRST = sctt_pkg::OP_READ + 3'd1;
    localparam logic [sctt_pkg::OP_W-1:0] OP_NONE_LAST  = '1;

    localparam longint TIME_CEIL = 64'h0000_0000_FFFF_FFFF;

    // ------------------------------------------------------------------
    // Mirror of the cue table plus the queue of results still owed.
    // ------------------------------------------------------------------
    class cue_window_checker;
        logic [sctt_pkg::TIME_W-1:0]   cue_time   [sctt_pkg::TABLE_DEPTH];
        logic [sctt_pkg::HANDLE_W-1:0] cue_handle [sctt_pkg::TABLE_DEPTH];
        int                            held;
        int                            shift_ms;
        sctt_pkg::t_result             due_results [$];
        int                            errors;
        int                            checked;
        int                            rejects;
        int                            op_tally [8];

        function int pending();
            return due_results.size();
        endfunction

        // Work out the result of one accepted operation and queue it.
        function void note_accepted_op(logic [sctt_pkg::OP_W-1:0] op,
                                       logic [sctt_pkg::TIME_W-1:0] tv,
                                       logic [sctt_pkg::HANDLE_W-1:0] th,
                                       logic [sctt_pkg::IDX_W-1:0] ei);
            sctt_pkg::t_result r;
            int                pos;
            int                n;
            int                i;
            longint            adj;
            r    = '0;
            r.ok = 1'b1;
            op_tally[op]++;
            case (op)
                sctt_pkg::OP_CLEAR: held = 0;
                sctt_pkg::OP_INSERT: begin
                    if (held >= sctt_pkg::TABLE_DEPTH) begin
                        r.ok = 1'b0;
                        rejects++;
                    end else begin
                        // stable: equal times stay ahead of the new entry
                        pos = held;
                        while (pos > 0 &&
                               cue_time[sctt_pkg::IDX_W'(pos - 1)] > tv) begin
                            cue_time[sctt_pkg::IDX_W'(pos)] =
                                cue_time[sctt_pkg::IDX_W'(pos - 1)];
                            cue_handle[sctt_pkg::IDX_W'(pos)] =
                                cue_handle[sctt_pkg::IDX_W'(pos - 1)];
                            pos--;
                        end
                        cue_time[sctt_pkg::IDX_W'(pos)]   = tv;
                        cue_handle[sctt_pkg::IDX_W'(pos)] = th;
                        held++;
                    end
                end
                sctt_pkg::OP_OFFSET: begin
                    if (shift_ms != 0) begin
                        for (i = 0; i < held; i++) begin
                            adj = longint'(cue_time[sctt_pkg::IDX_W'(i)]) +
                                  longint'(shift_ms);
                            if (adj < 0)
                                adj = 0;
                            else if (adj > TIME_CEIL)
                                adj = TIME_CEIL;
                            cue_time[sctt_pkg::IDX_W'(i)] = adj[sctt_pkg::TIME_W-1:0];
                        end
                    end
                end
                sctt_pkg::OP_FIND: begin
                    // table is sorted, so a plain count gives the last hit + 1
                    n = 0;
                    for (i = 0; i < held; i++)
                        if (cue_time[sctt_pkg::IDX_W'(i)] <= tv)
                            n++;
                    if (n > 0) begin
                        r.current_valid = 1'b1;
                        r.current_index = sctt_pkg::IDX_W'(n - 1);
                        r.exact_found   = 1'b1;
                        if (n > 1) begin
                            r.previous_valid = 1'b1;
                            r.previous_index = sctt_pkg::IDX_W'(n - 2);
                        end
                        if (n < held) begin
                            r.next_valid = 1'b1;
                            r.next_index = sctt_pkg::IDX_W'(n);
                        end
                    end else begin
                        // time precedes every entry: window starts at entry 0
                        if (held > 0)
                            r.current_valid = 1'b1;
                        if (held > 1) begin
                            r.next_valid = 1'b1;
                            r.next_index = sctt_pkg::IDX_W'(1);
                        end
                    end
                end
                sctt_pkg::OP_READ: begin
                    if (ei < held) begin
                        r.entry_time   = cue_time[ei];
                        r.entry_handle = cue_handle[ei];
                    end else begin
                        r.ok = 1'b0;
                    end
                end
                default: ;
            endcase
            r.entry_count = sctt_pkg::CNT_W'(held);
            due_results.push_back(r);
        endfunction

        function bit differs(string field, logic [sctt_pkg::TIME_W-1:0] want,
                             logic [sctt_pkg::TIME_W-1:0] got);
            if (want === got)
                return 1'b0;
            if (errors < 10)
                $display("  result %0d, %s: expected 0x%0h, got 0x%0h",
                         checked, field, want, got);
            return 1'b1;
        endfunction

        function void check_result(sctt_pkg::t_result got);
            sctt_pkg::t_result want;
            bit                bad;
            if (due_results.size() == 0) begin
                if (errors < 10)
                    $display("  result arrived with nothing pending at %0t", $realtime);
                errors++;
                return;
            end
            want = due_results.pop_front();
            checked++;
            bad = 1'b0;
            bad |= differs("ok", sctt_pkg::TIME_W'(want.ok), sctt_pkg::TIME_W'(got.ok));
            bad |= differs("current_valid", sctt_pkg::TIME_W'(want.current_valid),
                           sctt_pkg::TIME_W'(got.current_valid));
            bad |= differs("current_index", sctt_pkg::TIME_W'(want.current_index),
                           sctt_pkg::TIME_W'(got.current_index));
            bad |= differs("exact_found", sctt_pkg::TIME_W'(want.exact_found),
                           sctt_pkg::TIME_W'(got.exact_found));
            bad |= differs("previous_valid", sctt_pkg::TIME_W'(want.previous_valid),
                           sctt_pkg::TIME_W'(got.previous_valid));
            bad |= differs("previous_index", sctt_pkg::TIME_W'(want.previous_index),
                           sctt_pkg::TIME_W'(got.previous_index));
            bad |= differs("next_valid", sctt_pkg::TIME_W'(want.next_valid),
                           sctt_pkg::TIME_W'(got.next_valid));
            bad |= differs("next_index", sctt_pkg::TIME_W'(want.next_index),
                           sctt_pkg::TIME_W'(got.next_index));
            bad |= differs("entry_time", want.entry_time, got.entry_time);
            bad |= differs("entry_handle", sctt_pkg::TIME_W'(want.entry_handle),
                           sctt_pkg::TIME_W'(got.entry_handle));
            bad |= differs("entry_count", sctt_pkg::TIME_W'(want.entry_count),
                           sctt_pkg::TIME_W'(got.entry_count));
            if (bad)
                errors++;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [sctt_pkg::OP_W-1:0]     i_opcode;
    logic [sctt_pkg::TIME_W-1:0]   i_time_value;
    logic [sctt_pkg::HANDLE_W-1:0] i_text_handle;
    logic [sctt_pkg::IDX_W-1:0]    i_entry_index;
    logic                          i_cfg_we;
    logic [sctt_pkg::TIME_W-1:0]   i_cfg_wdata;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic                          o_ok;
    logic                          o_current_valid;
    logic [sctt_pkg::IDX_W-1:0]    o_current_index;
    logic                          o_exact_found;
    logic                          o_previous_valid;
    logic [sctt_pkg::IDX_W-1:0]    o_previous_index;
    logic                          o_next_valid;
    logic [sctt_pkg::IDX_W-1:0]    o_next_index;
    logic [sctt_pkg::TIME_W-1:0]   o_entry_time;
    logic [sctt_pkg::HANDLE_W-1:0] o_entry_handle;
    logic [sctt_pkg::CNT_W-1:0]    o_entry_count;

    cue_window_checker chk = new();

    bit idle_on;        // random gaps and stalls allowed
    int quiet_cycles;   // watchdog count

    sorted_cue_time_table_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_time_value     (i_time_value),
        .i_text_handle    (i_text_handle),
        .i_entry_index    (i_entry_index),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_ok             (o_ok),
        .o_current_valid  (o_current_valid),
        .o_current_index  (o_current_index),
        .o_exact_found    (o_exact_found),
        .o_previous_valid (o_previous_valid),
        .o_previous_index (o_previous_index),
        .o_next_valid     (o_next_valid),
        .o_next_index     (o_next_index),
        .o_entry_time     (o_entry_time),
        .o_entry_handle   (o_entry_handle),
        .o_entry_count    (o_entry_count)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. The result check
    // runs before the new op is noted, so an output transfer and an input
    // transfer on the same edge never pair up wrongly.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                chk.check_result(sctt_pkg::t_result'{
                    ok:             o_ok,
                    current_valid:  o_current_valid,
                    current_index:  o_current_index,
                    exact_found:    o_exact_found,
                    previous_valid: o_previous_valid,
                    previous_index: o_previous_index,
                    next_valid:     o_next_valid,
                    next_index:     o_next_index,
                    entry_time:     o_entry_time,
                    entry_handle:   o_entry_handle,
                    entry_count:    o_entry_count});
            if (i_in_valid && !o_in_stall)
                chk.note_accepted_op(i_opcode, i_time_value, i_text_handle, i_entry_index);
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Receiver back-pressure: random stall bursts while idle_on is set.
    initial begin : out_stall_gen
        int hold;
        hold        = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0)
                hold--;
            else if (idle_on && $urandom_range(0, 7) == 0)
                hold = $urandom_range(1, 14);
            i_out_stall = (hold > 0);
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------

    // One operation: optional idle burst, then hold it until the transfer.
    task automatic send_op(logic [sctt_pkg::OP_W-1:0] op,
                           logic [sctt_pkg::TIME_W-1:0] tv,
                           logic [sctt_pkg::HANDLE_W-1:0] th,
                           logic [sctt_pkg::IDX_W-1:0] ei);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_opcode      = op;
        i_time_value  = tv;
        i_text_handle = th;
        i_entry_index = ei;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Offset register write; only once every result is back.
    task automatic write_shift(int v);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we     = 1'b1;
        i_cfg_wdata  = v;
        chk.shift_ms = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Times: near held entries (hits, misses by one, duplicates), a narrow
    // range for collisions, the extremes, or anything at all.
    function automatic logic [sctt_pkg::TIME_W-1:0] pick_time();
        int                          sel;
        logic [sctt_pkg::TIME_W-1:0] t;
        sel = $urandom_range(0, 9);
        t   = $urandom;
        if (sel < 4 && chk.held > 0) begin
            t = chk.cue_time[sctt_pkg::IDX_W'($urandom_range(0, chk.held - 1))];
            if (sel == 0)
                t = t - 1;
            else if (sel == 1)
                t = t + 1;
        end else if (sel < 7) begin
            t = $urandom_range(0, 2000);
        end else if (sel == 7) begin
            t = ($urandom_range(0, 1) ? '1 : '0) ^
                sctt_pkg::TIME_W'($urandom_range(0, 1));
        end
        return t;
    endfunction

    // Random mix weighted toward inserts so the table builds up between
    // the rare clears. Reads mostly land inside the table.
    task automatic run_mix(int n_ops, int ins_pct);
        int                         w;
        logic [sctt_pkg::OP_W-1:0]  op;
        logic [sctt_pkg::IDX_W-1:0] ei;
        repeat (n_ops) begin
            w = $urandom_range(0, 99);
            if (w < ins_pct)
                op = sctt_pkg::OP_INSERT;
            else if (w < ins_pct + 25)
                op = sctt_pkg::OP_FIND;
            else if (w < ins_pct + 45)
                op = sctt_pkg::OP_READ;
            else if (w < ins_pct + 51)
                op = sctt_pkg::OP_OFFSET;
            else if (w < ins_pct + 53)
                op = sctt_pkg::OP_CLEAR;
            else
                op = sctt_pkg::OP_W'($urandom_range(OP_NONE_FIRST, OP_NONE_LAST));
            ei = sctt_pkg::IDX_W'($urandom);
            if (chk.held > 0 && $urandom_range(0, 2) != 0)
                ei = sctt_pkg::IDX_W'($urandom_range(0, chk.held - 1));
            send_op(op, pick_time(), sctt_pkg::HANDLE_W'($urandom), ei);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int k;
        int v;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_opcode      = sctt_pkg::OP_CLEAR;
        i_time_value  = '0;
        i_text_handle = '0;
        i_entry_index = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        idle_on       = 1'b1;
        quiet_cycles  = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed: empty table, then a small hand-built table ---
        send_op(sctt_pkg::OP_FIND,   32'd0, '0, '0);      // empty: every valid bit low
        send_op(sctt_pkg::OP_READ,   '0, '0, '0);         // read past the end of nothing
        send_op(sctt_pkg::OP_OFFSET, '0, '0, '0);         // offset register still zero
        send_op(sctt_pkg::OP_INSERT, 32'd1000, 16'h0000, '0);
        send_op(sctt_pkg::OP_FIND,   32'd999, '0, '0);    // ahead of the only entry
        send_op(sctt_pkg::OP_FIND,   32'd1000, '0, '0);   // single entry, no neighbors
        send_op(sctt_pkg::OP_INSERT, '0, '1, '0);
        send_op(sctt_pkg::OP_INSERT, '1, 16'h1234, '0);
        send_op(sctt_pkg::OP_INSERT, 32'd1000, 16'hAAAA, '0);  // equal times keep order
        send_op(sctt_pkg::OP_INSERT, 32'd1000, 16'h5555, '0);
        send_op(sctt_pkg::OP_READ,   '0, '0, 8'd2);
        send_op(sctt_pkg::OP_READ,   '0, '0, 8'd3);
        send_op(sctt_pkg::OP_READ,   '0, '0, '1);         // index past the count
        send_op(sctt_pkg::OP_FIND,   '1, '0, '0);         // last entry, no next
        send_op(sctt_pkg::OP_FIND,   32'd1000, '0, '0);   // lands on last of the equal run
        send_op(sctt_pkg::OP_FIND,   32'd500, '0, '0);
        for (k = OP_NONE_FIRST; k <= OP_NONE_LAST; k++)
            send_op(sctt_pkg::OP_W'(k), $urandom, sctt_pkg::HANDLE_W'($urandom),
                    sctt_pkg::IDX_W'($urandom));
        send_op(sctt_pkg::OP_OFFSET, '0, '0, '0);         // zero offset leaves times alone
        send_op(sctt_pkg::OP_CLEAR,  '1, '1, '1);
        send_op(sctt_pkg::OP_READ,   '0, '0, '0);         // stale entry behind a clear
        send_op(sctt_pkg::OP_INSERT, 32'd7, 16'h0101, '0);
        send_op(sctt_pkg::OP_INSERT, 32'd3, 16'h0202, '0);  // lands in front
        send_op(sctt_pkg::OP_FIND,   32'd0, '0, '0);      // precedes all, two entries
        write_shift(SHIFT_MAX);
        send_op(sctt_pkg::OP_INSERT, 32'hFFFF_FFF0, 16'h0303, '0);
        send_op(sctt_pkg::OP_OFFSET, '0, '0, '0);         // top entry saturates high
        send_op(sctt_pkg::OP_READ,   '0, '0, 8'd2);
        write_shift(SHIFT_MIN);
        send_op(sctt_pkg::OP_OFFSET, '0, '0, '0);
        send_op(sctt_pkg::OP_OFFSET, '0, '0, '0);         // low entries saturate at zero
        send_op(sctt_pkg::OP_READ,   '0, '0, 8'd0);

        // --- random phases, one offset setting each ---
        for (k = 0; k < 6; k++) begin
            idle_on = (k != 2);     // one phase runs back to back
            case (k)
                0: v = SHIFT_MAX;
                1: v = SHIFT_MIN;
                2: v = $urandom_range(1, 5000);
                3: v = -$urandom_range(1, 5000);
                5: v = 0;
                default: begin
                    v = $urandom;
                    if (v == SHIFT_MIN - 1)
                        v = SHIFT_MIN;
                end
            endcase
            write_shift(v);
            run_mix(50, 40);
        end

        // --- fill to capacity, then poke the full table ---
        idle_on = 1'b1;
        write_shift($urandom_range(1, 100000));
        send_op(sctt_pkg::OP_CLEAR, $urandom, sctt_pkg::HANDLE_W'($urandom),
                sctt_pkg::IDX_W'($urandom));
        while (chk.held < sctt_pkg::TABLE_DEPTH)
            run_mix(1, 85);
        repeat (4)                                        // turned away
            send_op(sctt_pkg::OP_INSERT, pick_time(), sctt_pkg::HANDLE_W'($urandom),
                    sctt_pkg::IDX_W'($urandom));
        send_op(sctt_pkg::OP_READ,   '0, '0, '1);
        send_op(sctt_pkg::OP_READ,   '0, '0, '0);
        send_op(sctt_pkg::OP_FIND,   '1, '0, '0);
        send_op(sctt_pkg::OP_FIND,   '0, '0, '0);
        send_op(sctt_pkg::OP_OFFSET, '0, '0, '0);         // walk all 256 entries
        send_op(sctt_pkg::OP_FIND,   pick_time(), '0, '0);

        // --- closing stretch with no gaps or stalls ---
        idle_on = 1'b0;
        write_shift(-$urandom_range(1, 100000));
        run_mix(60, 40);

        // drain, then give any stray result time to show up
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d ops: %0d clear, %0d insert (%0d refused full), %0d offset,",
                 chk.checked, chk.op_tally[sctt_pkg::OP_CLEAR],
                 chk.op_tally[sctt_pkg::OP_INSERT], chk.rejects,
                 chk.op_tally[sctt_pkg::OP_OFFSET]);
        $display("  %0d find, %0d read, %0d unused codes; %0d results in error",
                 chk.op_tally[sctt_pkg::OP_FIND], chk.op_tally[sctt_pkg::OP_READ],
                 chk.op_tally[5] + chk.op_tally[6] + chk.op_tally[7], chk.errors);
        if (chk.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
sv/sctt_pkg.sv
sv/sctt_mem.sv
sv/sctt_alu.sv
sv/sctt_seq.sv
sv/sorted_cue_time_table_top.sv
sv/sctt_chk.sv
bench/tb.sv
